FILE: hdl/cone_sector_intensity_macros.svh
// -----------------------------------------------------------------------------
// Cone sector intensity assertion macros
// Shared concurrent assertion forms used by the top level.
// -----------------------------------------------------------------------------
`ifndef CONE_SECTOR_INTENSITY_MACROS_SVH
`define CONE_SECTOR_INTENSITY_MACROS_SVH
`define CSI_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CSI_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: hdl/csi_pkg.sv
// -----------------------------------------------------------------------------
// Cone sector intensity package
// Widths, register indexes and the per-stage records of the two cell chains.
// -----------------------------------------------------------------------------
package csi_pkg;
   localparam int EYE_WIDTH = 16;
   localparam int FRAC_BITS = 16;
   localparam int CFG_WIDTH = 16;
   localparam int IDX_WIDTH = 3;
   localparam int SQ_WIDTH  = 2 * EYE_WIDTH + 2;
   localparam int LEN_WIDTH = EYE_WIDTH + 1;
   localparam int DOT_WIDTH = EYE_WIDTH + CFG_WIDTH + 2;
   localparam int PRD_WIDTH = LEN_WIDTH + CFG_WIDTH + 2;
   localparam int CMP_WIDTH = PRD_WIDTH + 2;
   localparam int INT_WIDTH = FRAC_BITS + 1;
   localparam int SQRT_CELLS = LEN_WIDTH;

   localparam logic [IDX_WIDTH-1:0] REG_AXIS_X    = 3'd0;
   localparam logic [IDX_WIDTH-1:0] REG_AXIS_Y    = 3'd1;
   localparam logic [IDX_WIDTH-1:0] REG_AXIS_Z    = 3'd2;
   localparam logic [IDX_WIDTH-1:0] REG_COS_INNER = 3'd3;
   localparam logic [IDX_WIDTH-1:0] REG_COS_OUTER = 3'd4;

   localparam logic [1:0] REGION_OUTSIDE = 2'd0;
   localparam logic [1:0] REGION_FADE    = 2'd1;
   localparam logic [1:0] REGION_INSIDE  = 2'd2;

   // record carried from cell to cell of the square-root chain
   typedef struct packed {
      logic                          valid;
      logic [SQ_WIDTH-1:0]           rem;
      logic [SQ_WIDTH-1:0]           root;
      logic signed [DOT_WIDTH-1:0]   dot;
   } sqrt_rec_type;

   // record carried from cell to cell of the divider chain
   typedef struct packed {
      logic                          valid;
      logic                          done;
      logic [1:0]                    region;
      logic [CMP_WIDTH-1:0]          rem;
      logic [CMP_WIDTH-1:0]          den;
      logic [INT_WIDTH-1:0]          quo;
   } div_rec_type;
endpackage

FILE: hdl/csi_stream_if.sv
// -----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of configurable type between source and sink.
// -----------------------------------------------------------------------------
interface csi_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/csi_sqrt_cell.sv
// -----------------------------------------------------------------------------
// Square-root cell
// Resolves one root bit per cycle while advance is high; feeds the next cell.
// -----------------------------------------------------------------------------
module csi_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [csi_pkg::SQ_WIDTH-1:0] bit_val,
   input  csi_pkg::sqrt_rec_type       rec_in,
   output csi_pkg::sqrt_rec_type       rec_out
);
   csi_pkg::sqrt_rec_type rec_ff, rec_in_w;
   logic [csi_pkg::SQ_WIDTH-1:0] trial, res_w;

   always_comb begin
      res_w = rec_in.root;
      trial = res_w + bit_val;
      rec_in_w = rec_in;
      if (rec_in.rem >= trial) begin
         rec_in_w.rem  = rec_in.rem - trial;
         rec_in_w.root = (res_w >> 1) + bit_val;
      end else begin
         rec_in_w.root = res_w >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (advance) begin
         rec_ff.valid <= rec_in.valid;
      end
      if (advance) begin
         rec_ff.rem  <= rec_in_w.rem;
         rec_ff.root <= rec_in_w.root;
         rec_ff.dot  <= rec_in.dot;
      end
   end

   assign rec_out = rec_ff;
endmodule

FILE: hdl/csi_div_cell.sv
// -----------------------------------------------------------------------------
// Divider cell
// Adds one quotient bit per cycle by restoring division unless done is set; holds while advance is low.
// -----------------------------------------------------------------------------
module csi_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  csi_pkg::div_rec_type rec_in,
   output csi_pkg::div_rec_type rec_out
);
   csi_pkg::div_rec_type rec_ff, rec_in_w;
   logic [csi_pkg::CMP_WIDTH:0] shifted;

   always_comb begin
      rec_in_w = rec_in;
      shifted  = {rec_in.rem, 1'b0};
      if (!rec_in.done) begin
         rec_in_w.quo = {rec_in.quo[csi_pkg::INT_WIDTH-2:0], 1'b0};
         if (shifted >= {1'b0, rec_in.den}) begin
            rec_in_w.quo[0] = 1'b1;
            rec_in_w.rem = csi_pkg::CMP_WIDTH'(shifted - {1'b0, rec_in.den});
         end else begin
            rec_in_w.rem = csi_pkg::CMP_WIDTH'(shifted);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (advance) begin
         rec_ff.valid <= rec_in.valid;
      end
      if (advance) begin
         rec_ff.done   <= rec_in_w.done;
         rec_ff.region <= rec_in_w.region;
         rec_ff.rem    <= rec_in_w.rem;
         rec_ff.den    <= rec_in_w.den;
         rec_ff.quo    <= rec_in_w.quo;
      end
   end

   assign rec_out = rec_ff;
endmodule

FILE: hdl/cone_sector_intensity.sv
// Stages: products, sums, square-root cells, scaled thresholds, region decision, divider cells, output register.
// Throughput: one transaction per cycle; the whole pipeline holds on output stall.
// Each square-root cell resolves one root bit and each divider cell
// one quotient bit; the chain length sets the latency.
// Reset clears all valid flags and loads axis (0,0,1.0) and both cosines 1.0.
// -----------------------------------------------------------------------------
// Cone sector intensity
// Dot product, integer length, region test and fade ratio as a cell chain.
// -----------------------------------------------------------------------------
`include "cone_sector_intensity_macros.svh"
module cone_sector_intensity (
   input  logic clock,
   input  logic reset,
   csi_stream_if.sink   req,
   csi_stream_if.source rsp,
   csi_stream_if.sink   csr
);
   localparam int NS = csi_pkg::SQRT_CELLS;
   localparam int NF = csi_pkg::FRAC_BITS;
   localparam int SW = csi_pkg::SQ_WIDTH;
   localparam int DW = csi_pkg::DOT_WIDTH;
   localparam int PW = csi_pkg::PRD_WIDTH;
   localparam int CW = csi_pkg::CMP_WIDTH;
   localparam int IW = csi_pkg::INT_WIDTH;
   localparam int EW = csi_pkg::EYE_WIDTH;
   localparam int FW = csi_pkg::CFG_WIDTH;

   logic signed [FW-1:0] axis_x_ff, axis_y_ff, axis_z_ff, cos_in_ff, cos_out_ff;
   logic advance;

   // output register
   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_int_ff;
   logic [1:0]    rsp_reg_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff  <= '0;
         axis_y_ff  <= '0;
         axis_z_ff  <= FW'(16384);
         cos_in_ff  <= FW'(16384);
         cos_out_ff <= FW'(16384);
      end else if (csr.valid) begin
         case (csr.data.index)
            csi_pkg::REG_AXIS_X:    axis_x_ff  <= csr.data.value;
            csi_pkg::REG_AXIS_Y:    axis_y_ff  <= csr.data.value;
            csi_pkg::REG_AXIS_Z:    axis_z_ff  <= csr.data.value;
            csi_pkg::REG_COS_INNER: cos_in_ff  <= csr.data.value;
            csi_pkg::REG_COS_OUTER: cos_out_ff <= csr.data.value;
            default: ;
         endcase
      end
   end

   // stage 1: products
   logic          s1_valid_ff;
   logic signed [EW+FW-1:0] px_ff, py_ff, pz_ff;
   logic [2*EW-1:0] qx_ff, qy_ff, qz_ff;
   logic [EW-1:0] ax_w, ay_w, az_w;

   always_comb begin
      ax_w = req.data.eye_x[EW-1] ? EW'(-req.data.eye_x) : EW'(req.data.eye_x);
      ay_w = req.data.eye_y[EW-1] ? EW'(-req.data.eye_y) : EW'(req.data.eye_y);
      az_w = req.data.eye_z[EW-1] ? EW'(-req.data.eye_z) : EW'(req.data.eye_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
      if (advance) begin
         px_ff <= req.data.eye_x * axis_x_ff;
         py_ff <= req.data.eye_y * axis_y_ff;
         pz_ff <= req.data.eye_z * axis_z_ff;
         qx_ff <= ax_w * ax_w;
         qy_ff <= ay_w * ay_w;
         qz_ff <= az_w * az_w;
      end
   end

   // stage 2: sums
   logic          s2_valid_ff;
   logic signed [DW-1:0] dot_ff;
   logic [SW-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         dot_ff <= DW'(px_ff) + DW'(py_ff) + DW'(pz_ff);
         sq_ff  <= SW'(qx_ff) + SW'(qy_ff) + SW'(qz_ff);
      end
   end

   // square-root chain
   csi_pkg::sqrt_rec_type srec [0:NS];
   assign srec[0].valid = s2_valid_ff;
   assign srec[0].rem   = sq_ff;
   assign srec[0].root  = '0;
   assign srec[0].dot   = dot_ff;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      csi_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .bit_val (SW'(1) << (2 * (NS - 1 - g))),
         .rec_in  (srec[g]),
         .rec_out (srec[g+1])
      );
   end

   // stage A: scaled thresholds
   logic          sa_valid_ff;
   logic signed [DW-1:0] sa_dot_ff;
   logic          sa_zero_ff;
   logic signed [PW-1:0] ci_l_ff, co_l_ff, den_ff;
   logic signed [csi_pkg::LEN_WIDTH:0] len_s;
   logic signed [FW:0] cdiff;

   assign len_s = {1'b0, srec[NS].root[csi_pkg::LEN_WIDTH-1:0]};
   assign cdiff = (FW+1)'(cos_in_ff) - (FW+1)'(cos_out_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= srec[NS].valid;
      end
      if (advance) begin
         sa_dot_ff  <= srec[NS].dot;
         sa_zero_ff <= (srec[NS].root == '0);
         ci_l_ff    <= PW'(cos_in_ff) * PW'(len_s);
         co_l_ff    <= PW'(cos_out_ff) * PW'(len_s);
         den_ff     <= PW'(cdiff) * PW'(len_s);
      end
   end

   // stage B: region decision and divider seed
   csi_pkg::div_rec_type drec [0:NF];
   logic signed [CW-1:0] dot_c, ci_c, co_c, den_c, num_c;

   always_comb begin
      dot_c = CW'(sa_dot_ff);
      ci_c  = CW'(ci_l_ff);
      co_c  = CW'(co_l_ff);
      den_c = CW'(den_ff);
      num_c = dot_c - co_c;
   end

   csi_pkg::div_rec_type sb_ff, sb_in;
   always_comb begin
      sb_in.valid  = sa_valid_ff;
      sb_in.done   = 1'b1;
      sb_in.rem    = CW'(num_c);
      sb_in.den    = CW'(den_c);
      sb_in.quo    = '0;
      sb_in.region = csi_pkg::REGION_OUTSIDE;
      if (sa_zero_ff) begin
         sb_in.region = csi_pkg::REGION_OUTSIDE;
      end else if (dot_c > ci_c) begin
         sb_in.region = csi_pkg::REGION_INSIDE;
         sb_in.quo    = IW'(1) << NF;
      end else if (dot_c < co_c) begin
         sb_in.region = csi_pkg::REGION_OUTSIDE;
      end else if (den_c <= 0) begin
         sb_in.region = csi_pkg::REGION_INSIDE;
         sb_in.quo    = IW'(1) << NF;
      end else if (num_c >= den_c) begin
         sb_in.region = csi_pkg::REGION_FADE;
         sb_in.quo    = IW'(1) << NF;
      end else begin
         sb_in.region = csi_pkg::REGION_FADE;
         sb_in.done   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff.valid <= 1'b0;
      end else if (advance) begin
         sb_ff.valid <= sb_in.valid;
      end
      if (advance) begin
         sb_ff.done   <= sb_in.done;
         sb_ff.region <= sb_in.region;
         sb_ff.rem    <= sb_in.rem;
         sb_ff.den    <= sb_in.den;
         sb_ff.quo    <= sb_in.quo;
      end
   end

   assign drec[0] = sb_ff;

   for (genvar g = 0; g < NF; g++) begin : g_div
      csi_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .rec_in  (drec[g]),
         .rec_out (drec[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= drec[NF].valid;
      end
      if (advance) begin
         rsp_int_ff <= drec[NF].quo;
         rsp_reg_ff <= drec[NF].region;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.data.intensity = rsp_int_ff;
   assign rsp.data.region    = rsp_reg_ff;

   `CSI_ASSERT_NEXT(a_hold_stall, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.data.intensity))
   `CSI_ASSERT_IMPL(a_full_inside, clock, reset,
      rsp.valid && rsp.data.region == csi_pkg::REGION_INSIDE,
      rsp.data.intensity == (IW'(1) << NF))
   `CSI_ASSERT_IMPL(a_zero_outside, clock, reset,
      rsp.valid && rsp.data.region == csi_pkg::REGION_OUTSIDE,
      rsp.data.intensity == '0)
endmodule

FILE: bench/tb.sv
// -----------------------------------------------------------------------------
// Cone sector intensity testbench
// Drives eye vectors through the valid/ready input channel while checking
// every result in order against a built-in fixed-point cone model. The run
// walks several axis and cosine settings, including the register extremes,
// and varies sender and receiver idling.
// -----------------------------------------------------------------------------
module tb;
   typedef struct packed {
      logic signed [csi_pkg::EYE_WIDTH-1:0] eye_x;
      logic signed [csi_pkg::EYE_WIDTH-1:0] eye_y;
      logic signed [csi_pkg::EYE_WIDTH-1:0] eye_z;
   } eye_vec_type;

   typedef struct packed {
      logic [csi_pkg::INT_WIDTH-1:0] intensity;
      logic [1:0]                    region;
   } light_type;

   typedef struct packed {
      logic [csi_pkg::IDX_WIDTH-1:0] index;
      logic [csi_pkg::CFG_WIDTH-1:0] value;
   } csr_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csi_stream_if #(.payload_type(eye_vec_type))   req ();
   csi_stream_if #(.payload_type(light_type))     rsp ();
   csi_stream_if #(.payload_type(csr_write_type)) csr ();

   cone_sector_intensity dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   eye_vec_type   vec_pending[$];
   light_type     light_expected[$];
   longint        cone_reg[5];
   int            src_idle = 0;
   int            snk_idle = 0;
   int            errors = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic light_type cone_light(eye_vec_type v);
      light_type o;
      longint ex, ey, ez, len, d, ci_l, co_l, den, num;
      longint unsigned r, dn, q, full;
      full = 64'd1 << csi_pkg::FRAC_BITS;
      ex = v.eye_x;
      ey = v.eye_y;
      ez = v.eye_z;
      len = longint'(isqrt(longint'(ex * ex + ey * ey + ez * ez)));
      d = ex * cone_reg[csi_pkg::REG_AXIS_X] + ey * cone_reg[csi_pkg::REG_AXIS_Y]
          + ez * cone_reg[csi_pkg::REG_AXIS_Z];
      ci_l = cone_reg[csi_pkg::REG_COS_INNER] * len;
      co_l = cone_reg[csi_pkg::REG_COS_OUTER] * len;
      if (len == 0) begin
         o.intensity = '0;
         o.region = csi_pkg::REGION_OUTSIDE;
      end else if (d > ci_l) begin
         o.intensity = full[csi_pkg::INT_WIDTH-1:0];
         o.region = csi_pkg::REGION_INSIDE;
      end else if (d < co_l) begin
         o.intensity = '0;
         o.region = csi_pkg::REGION_OUTSIDE;
      end else begin
         den = (cone_reg[csi_pkg::REG_COS_INNER] - cone_reg[csi_pkg::REG_COS_OUTER]) * len;
         num = d - co_l;
         if (den <= 0) begin
            o.intensity = full[csi_pkg::INT_WIDTH-1:0];
            o.region = csi_pkg::REGION_INSIDE;
         end else begin
            o.region = csi_pkg::REGION_FADE;
            r = (num < 0) ? 64'd0 : unsigned'(num);
            dn = unsigned'(den);
            q = 0;
            if (r >= dn) begin
               q = full;
            end else begin
               for (int i = 0; i < csi_pkg::FRAC_BITS; i++) begin
                  r <<= 1;
                  q <<= 1;
                  if (r >= dn) begin
                     q |= 1;
                     r -= dn;
                  end
               end
               if (q > full) q = full;
            end
            o.intensity = q[csi_pkg::INT_WIDTH-1:0];
         end
      end
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= snk_idle);
         if (!req.valid || req.ready) begin
            if (vec_pending.size() > 0 && $urandom_range(99) >= src_idle) begin
               req.data  <= vec_pending.pop_front();
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      light_type want;
      if (!reset) begin
         if (req.valid && req.ready) light_expected.push_back(cone_light(req.data));
         if (rsp.valid && rsp.ready) begin
            if (light_expected.size() == 0) begin
               report("unexpected transaction", rsp.data.intensity, -1);
            end else begin
               want = light_expected.pop_front();
               if (rsp.data.intensity !== want.intensity)
                  report("intensity", rsp.data.intensity, want.intensity);
               if (rsp.data.region !== want.region)
                  report("region", rsp.data.region, want.region);
            end
         end
      end
   end

   task automatic drain();
      while (vec_pending.size() > 0 || req.valid || light_expected.size() > 0)
         @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [csi_pkg::IDX_WIDTH-1:0] idx,
                            logic [csi_pkg::CFG_WIDTH-1:0] val);
      csr.data  <= '{index: idx, value: val};
      csr.valid <= 1'b1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      if (idx < 5) cone_reg[idx] = longint'($signed(val));
      @(posedge clock);
   endtask

   task automatic set_cone(int ax, int ay, int az, int ci, int co);
      write_reg(csi_pkg::REG_AXIS_X, ax[15:0]);
      write_reg(csi_pkg::REG_AXIS_Y, ay[15:0]);
      write_reg(csi_pkg::REG_AXIS_Z, az[15:0]);
      write_reg(csi_pkg::REG_COS_INNER, ci[15:0]);
      write_reg(csi_pkg::REG_COS_OUTER, co[15:0]);
   endtask

   task automatic add_vec(int x, int y, int z);
      eye_vec_type v;
      v.eye_x = x[15:0];
      v.eye_y = y[15:0];
      v.eye_z = z[15:0];
      vec_pending.push_back(v);
   endtask

   function automatic int rnd_field(int near);
      case ($urandom_range(3))
         0: return $urandom_range(65535) - 32768;
         1: return $urandom_range(200) - 100;
         2: return near;
         default: return $urandom_range(4000) - 2000;
      endcase
   endfunction

   task automatic random_vecs(int n);
      int z;
      for (int i = 0; i < n; i++) begin
         z = $urandom_range(32767);
         add_vec(rnd_field($urandom_range(z / 2)), rnd_field($urandom_range(z / 3)),
                 $urandom_range(1) ? z : -z);
      end
   endtask

   initial begin
      int cfg_vals[5];
      cone_reg = '{0, 0, 16384, 16384, 16384};
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: zero vector and equal cosines
      add_vec(0, 0, 0);
      add_vec(0, 0, 100);
      add_vec(0, 0, -100);
      add_vec(32767, 32767, 32767);
      add_vec(-32768, -32768, -32768);
      add_vec(-32768, 0, 0);
      add_vec(0, 32767, 0);
      drain();

      set_cone(0, 0, 16384, 16384, 8000);
      add_vec(0, 0, 7);
      add_vec(3, 4, 12);
      add_vec(100, 0, 100);
      add_vec(0, -32768, 32767);
      add_vec(32767, -32768, 1);
      add_vec(0, 0, -7);
      drain();

      set_cone(-16384, 16384, -16384, -16384, 16384);
      add_vec(-100, 100, -100);
      add_vec(1, 1, 1);
      add_vec(-32768, 32767, -32768);
      drain();

      set_cone(0, 0, 16384, 14000, 10000);
      write_reg(3'd5, 16'h1234);
      write_reg(3'd7, 16'hffff);
      add_vec(5000, 0, 10000);
      add_vec(0, 9000, 12000);
      add_vec(-7000, 3000, 11000);
      add_vec(32767, 32767, -32768);
      drain();

      set_cone(-32768, 32767, 32767, -32768, -32768);
      add_vec(1234, -4321, 32767);
      add_vec(-32768, 32767, 32767);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         src_idle = (ph < 3) ? 29 : (ph < 6) ? 70 : 0;
         snk_idle = (ph < 3) ? 70 : (ph < 6) ? 29 : 0;
         if (ph == 0) begin
            set_cone(0, 0, 16384, 16000, 12000);
         end else if (ph == 4) begin
            set_cone(0, 0, -16384, 16384, -16384);
         end else begin
            foreach (cfg_vals[k]) cfg_vals[k] = $urandom_range(32768) - 16384;
            if ($urandom_range(1)) begin
               cfg_vals[0] = $urandom_range(2000) - 1000;
               cfg_vals[1] = $urandom_range(2000) - 1000;
               cfg_vals[2] = 16000;
               cfg_vals[3] = $urandom_range(16384, 12000);
               cfg_vals[4] = $urandom_range(12000, 4000);
            end
            set_cone(cfg_vals[0], cfg_vals[1], cfg_vals[2], cfg_vals[3], cfg_vals[4]);
         end
         random_vecs(22);
         if (ph == 2) drain();
         random_vecs(22);
         drain();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
